### sv/assert_macros.svh
// assertion macros shared by the floor texture coordinate stepper
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge, off while reset is high
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition holds while a qualifier is high
`define ASSERT_WHEN(label, clock, reset, cond, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) else $error(msg);

`endif

### sv/fts_pkg.sv
// types, constants and helper functions of the floor texture coordinate stepper
// no dependencies; imported by every module of the block
package fts_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_TEX_LOG2 = 10;
  localparam int SCR_W        = 12;
  localparam int PIX_W        = 11;
  localparam int DIR_W        = 21;
  localparam int POS_W        = 32;
  localparam int ACC_W        = 32;
  localparam int TEX_W        = 10;
  localparam int TLOG_W       = 4;
  localparam int CFG_W        = 32;
  localparam int IDX_W        = 3;
  localparam int RD_W         = SCR_W + FRAC_BITS;
  localparam int RDS_W        = RD_W + 1;
  localparam int OP_W         = DIR_W + 2;
  localparam int PROD_W       = RDS_W + OP_W;
  localparam int DIV_NW       = PROD_W - FRAC_BITS;
  localparam int SUM_W        = DIV_NW + 2;
  localparam int CNT_W        = $clog2(DIV_NW + 1);

  typedef enum logic [IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_TEX_W_LOG2    = 3'd2,
    REG_TEX_H_LOG2    = 3'd3,
    REG_DIR_X         = 3'd4,
    REG_DIR_Y         = 3'd5,
    REG_POS_X         = 3'd6,
    REG_POS_Y         = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SCR_W-1:0]        scr_cols;
    logic [SCR_W-1:0]        scr_rows;
    logic [TLOG_W-1:0]       tex_w_log2;
    logic [TLOG_W-1:0]       tex_h_log2;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] column;
    logic             horizon;
    logic             col_zero;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [SCR_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  // texture coordinate from the fraction of a world value, truncated toward zero
  function automatic logic [TEX_W-1:0] tex_coord(input logic [ACC_W-1:0] acc,
                                                 input logic [TLOG_W-1:0] tlog);
    logic [TLOG_W-1:0]          t;
    logic [ACC_W-1:0]           mag;
    logic [FRAC_BITS+TEX_W-1:0] sh;
    logic [TEX_W-1:0]           v;
    logic [TEX_W-1:0]           mask;
    t    = (tlog > TLOG_W'(MAX_TEX_LOG2)) ? TLOG_W'(MAX_TEX_LOG2) : tlog;
    mag  = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
    sh   = {{TEX_W{1'b0}}, mag[FRAC_BITS-1:0]} << t;
    v    = sh[FRAC_BITS+TEX_W-1:FRAC_BITS];
    if (acc[ACC_W-1]) v = ~v + 1'b1;
    mask = ~({TEX_W{1'b1}} << t);
    return v & mask;
  endfunction

  // signed saturation of a magnitude and sign to the accumulator width
  function automatic logic [ACC_W-1:0] sat_mag(input logic [DIV_NW-1:0] mag,
                                               input logic neg);
    logic [ACC_W-1:0] r;
    if (!neg) begin
      if (mag > DIV_NW'({1'b0, {(ACC_W-1){1'b1}}})) r = {1'b0, {(ACC_W-1){1'b1}}};
      else r = mag[ACC_W-1:0];
    end else begin
      if (mag > DIV_NW'({1'b1, {(ACC_W-1){1'b0}}})) r = {1'b1, {(ACC_W-1){1'b0}}};
      else r = ~mag[ACC_W-1:0] + 1'b1;
    end
    return r;
  endfunction

  // signed saturation of a wide sum to the accumulator width
  function automatic logic [ACC_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic [ACC_W-1:0]        r;
    hi = SUM_W'($signed({1'b0, {(ACC_W-1){1'b1}}}));
    lo = SUM_W'($signed({1'b1, {(ACC_W-1){1'b0}}}));
    if (v > hi) r = hi[ACC_W-1:0];
    else if (v < lo) r = lo[ACC_W-1:0];
    else r = v[ACC_W-1:0];
    return r;
  endfunction

endpackage

### sv/fts_front.sv
// front end: takes pixel words, flags horizon and row start, two-entry queue
// depends on fts_pkg
module fts_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [fts_pkg::SCR_W-1:0]  scr_rows,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fts_pkg::PIX_W-1:0]  row,
  input  logic [fts_pkg::PIX_W-1:0]  column,
  output logic                       q_valid,
  output fts_pkg::item_t             q_item,
  input  logic                       q_pop
);
  import fts_pkg::*;

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rptr];

  always_comb begin
    cls.row      = row;
    cls.column   = column;
    cls.horizon  = (row == scr_rows[SCR_W-1:1]);
    cls.col_zero = (column == '0);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/fts_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on fts_pkg
module fts_div (
  input  logic               clk,
  input  logic               rst,
  input  fts_pkg::div_req_t  req,
  output fts_pkg::div_rsp_t  rsp
);
  import fts_pkg::*;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [SCR_W-1:0]  rem;
  logic [SCR_W-1:0]  den_r;
  logic [DIV_NW-1:0] numsh;
  logic [DIV_NW-1:0] quo;
  logic [SCR_W:0]    rem_sh;
  logic              ge;

  assign rem_sh   = {rem, numsh[DIV_NW-1]};
  assign ge       = (rem_sh >= {1'b0, den_r});
  assign rsp.done = done;
  assign rsp.quo  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(DIV_NW);
        rem   <= '0;
        numsh <= req.num;
        den_r <= req.den;
        quo   <= '0;
      end else if (busy) begin
        rem   <= ge ? SCR_W'(rem_sh - {1'b0, den_r}) : rem_sh[SCR_W-1:0];
        numsh <= numsh << 1;
        quo   <= {quo[DIV_NW-2:0], ge};
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/fts_back.sv
// back end: row setup sequencer, world accumulators and output register
// depends on fts_pkg and fts_div
module fts_back (
  input  logic                       clk,
  input  logic                       rst,
  input  fts_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  fts_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fts_pkg::TEX_W-1:0]  tex_x,
  output logic [fts_pkg::TEX_W-1:0]  tex_y,
  output logic [fts_pkg::PIX_W-1:0]  out_row,
  output logic [fts_pkg::PIX_W-1:0]  out_column,
  output logic                       on_horizon
);
  import fts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_MUL  = 6'b000100,
    S_DSX  = 6'b001000,
    S_DSY  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                   state;
  logic [2:0]               mcnt;
  logic signed [RDS_W-1:0]  rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DIV_NW-1:0]        sx_mag;
  logic [DIV_NW-1:0]        sy_mag;
  logic                     sx_neg;
  logic                     sy_neg;
  logic [ACC_W-1:0]         world_x_acc;
  logic [ACC_W-1:0]         world_y_acc;
  logic [ACC_W-1:0]         step_x;
  logic [ACC_W-1:0]         step_y;

  logic [PIX_W-1:0]         half;
  logic signed [PIX_W:0]    p;
  logic [PIX_W-1:0]         p_mag;
  logic [SCR_W-1:0]         w_eff;
  logic signed [OP_W-1:0]   dxe;
  logic signed [OP_W-1:0]   dye;
  logic signed [OP_W-1:0]   op_sel;
  logic                     prod_neg;
  logic [PROD_W-1:0]        prod_mag;
  logic [DIV_NW-1:0]        shr;
  logic signed [SUM_W-1:0]  t_s;
  logic signed [SUM_W-1:0]  pos_sel;
  logic signed [SUM_W-1:0]  sum;
  logic                     out_free;
  logic                     need_setup;
  logic                     emit;
  logic [RD_W-1:0]          rd_mag;
  div_req_t                 dreq;
  div_rsp_t                 drsp;

  fts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign half       = cfg.scr_rows[SCR_W-1:1];
  assign p          = $signed({1'b0, q_item.row}) - $signed({1'b0, half});
  assign p_mag      = p[PIX_W] ? PIX_W'(-p) : p[PIX_W-1:0];
  assign w_eff      = (cfg.scr_cols == '0) ? SCR_W'(1) : cfg.scr_cols;
  assign dxe        = OP_W'(cfg.dir_x);
  assign dye        = OP_W'(cfg.dir_y);
  assign out_free   = !out_valid || out_ready;
  assign need_setup = q_item.col_zero && !q_item.horizon;
  assign emit       = ((state == S_IDLE) && q_valid && !need_setup && out_free) ||
                      ((state == S_OUT) && out_free);
  assign q_pop      = emit;
  assign rd_mag     = drsp.quo[RD_W-1:0];

  always_comb begin
    case (mcnt)
      3'd0:    op_sel = -(dye + dye);
      3'd1:    op_sel = dxe + dxe;
      3'd2:    op_sel = dxe + dye;
      default: op_sel = dye - dxe;
    endcase
  end

  // post-multiply: magnitude, drop fraction bits, then signed for the world sums
  assign prod_neg = prod_r[PROD_W-1];
  assign prod_mag = prod_neg ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign shr      = prod_mag[PROD_W-1:FRAC_BITS];
  assign t_s      = prod_neg ? -$signed({2'b00, shr}) : $signed({2'b00, shr});
  assign pos_sel  = (mcnt == 3'd3) ? SUM_W'(cfg.pos_x) : SUM_W'(cfg.pos_y);
  assign sum      = pos_sel + t_s;

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = sx_mag;
    dreq.den   = w_eff;
    case (state)
      S_IDLE: begin
        dreq.start = q_valid && need_setup;
        dreq.num   = DIV_NW'({cfg.scr_rows, {FRAC_BITS{1'b0}}});
        dreq.den   = SCR_W'({p_mag, 1'b0});
      end
      S_MUL: begin
        dreq.start = (mcnt == 3'd4);
        dreq.num   = sx_mag;
      end
      S_DSX: begin
        dreq.start = drsp.done;
        dreq.num   = sy_mag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mcnt        <= 3'd0;
      out_valid   <= 1'b0;
      world_x_acc <= '0;
      world_y_acc <= '0;
      step_x      <= '0;
      step_y      <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && need_setup) state <= S_RD;
        end
        S_RD: begin
          if (drsp.done) begin
            rd_r  <= p[PIX_W] ? -$signed({1'b0, rd_mag}) : $signed({1'b0, rd_mag});
            mcnt  <= 3'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mcnt != 3'd4) prod_r <= rd_r * op_sel;
          case (mcnt)
            3'd1: begin
              sx_mag <= shr;
              sx_neg <= prod_neg;
            end
            3'd2: begin
              sy_mag <= shr;
              sy_neg <= prod_neg;
            end
            3'd3: world_x_acc <= sat_sum(sum);
            3'd4: world_y_acc <= sat_sum(sum);
            default: ;
          endcase
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) state <= S_DSX;
        end
        S_DSX: begin
          if (drsp.done) begin
            step_x <= sat_mag(drsp.quo, sx_neg);
            state  <= S_DSY;
          end
        end
        S_DSY: begin
          if (drsp.done) begin
            step_y <= sat_mag(drsp.quo, sy_neg);
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (emit) begin
        if (q_item.horizon) begin
          if (q_item.col_zero) begin
            world_x_acc <= '0;
            world_y_acc <= '0;
            step_x      <= '0;
            step_y      <= '0;
          end
        end else begin
          world_x_acc <= world_x_acc + step_x;
          world_y_acc <= world_y_acc + step_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tex_x      <= q_item.horizon ? '0 : tex_coord(world_x_acc, cfg.tex_w_log2);
      tex_y      <= q_item.horizon ? '0 : tex_coord(world_y_acc, cfg.tex_h_log2);
      out_row    <= q_item.row;
      out_column <= q_item.column;
      on_horizon <= q_item.horizon;
    end
  end

endmodule

### sv/floor_texture_coord_stepper.sv
// Floor texture coordinate stepper. Pixels come in raster order as (row, column);
// each word out carries the texture coordinates of the floor point under that pixel.
// A pixel with a nonzero column, or any pixel on the horizon row, needs no setup, and
// words can follow back to back while the output is not stalled. A pixel at column 0 off
// the horizon starts a row setup: three divisions on a shared serial divider at one
// quotient bit per cycle, plus the multiply and sequencing steps, after which its word
// is issued. A two-word queue in front lets input keep flowing while setup runs, and the
// output register lets the next word be prepared while the last one waits. Configuration
// is to be written through cfg_write/cfg_index/cfg_data only while no pixel is in flight;
// the user is bound by this, and the block itself does not enforce it.
// depends on fts_pkg, fts_front, fts_back, fts_div and assert_macros.svh
`include "assert_macros.svh"

module floor_texture_coord_stepper (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_write,
  input  logic [fts_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fts_pkg::CFG_W-1:0]  cfg_data,
  // pixel input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fts_pkg::PIX_W-1:0]  row,
  input  logic [fts_pkg::PIX_W-1:0]  column,
  // texture coordinate output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fts_pkg::TEX_W-1:0]  tex_x,
  output logic [fts_pkg::TEX_W-1:0]  tex_y,
  output logic [fts_pkg::PIX_W-1:0]  out_row,
  output logic [fts_pkg::PIX_W-1:0]  out_column,
  output logic                       on_horizon
);
  import fts_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // configuration registers, reset to a 640x480 screen, 64x64 texture, facing +x
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scr_cols   <= SCR_W'(640);
      cfg.scr_rows   <= SCR_W'(480);
      cfg.tex_w_log2 <= TLOG_W'(6);
      cfg.tex_h_log2 <= TLOG_W'(6);
      cfg.dir_x      <= DIR_W'(65536);
      cfg.dir_y      <= '0;
      cfg.pos_x      <= '0;
      cfg.pos_y      <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg.scr_cols   <= cfg_data[SCR_W-1:0];
        REG_SCREEN_HEIGHT: cfg.scr_rows   <= cfg_data[SCR_W-1:0];
        REG_TEX_W_LOG2:    cfg.tex_w_log2 <= cfg_data[TLOG_W-1:0];
        REG_TEX_H_LOG2:    cfg.tex_h_log2 <= cfg_data[TLOG_W-1:0];
        REG_DIR_X:         cfg.dir_x      <= $signed(cfg_data[DIR_W-1:0]);
        REG_DIR_Y:         cfg.dir_y      <= $signed(cfg_data[DIR_W-1:0]);
        REG_POS_X:         cfg.pos_x      <= $signed(cfg_data[POS_W-1:0]);
        REG_POS_Y:         cfg.pos_y      <= $signed(cfg_data[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  // front: classify each word (horizon, row start) and queue it
  fts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .scr_rows (cfg.scr_rows),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .row      (row),
    .column   (column),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: row setup, accumulator stepping and the output register
  fts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tex_x      (tex_x),
    .tex_y      (tex_y),
    .out_row    (out_row),
    .out_column (out_column),
    .on_horizon (on_horizon)
  );

  // horizon words always carry zero coordinates
  `ASSERT_WHEN(a_horizon_zero, clk, rst, out_valid && on_horizon, (tex_x == '0) && (tex_y == '0), "horizon word with nonzero coordinates")
  // an accepted word is in the queue on the next cycle
  `ASSERT_WHEN(a_accept_queued, clk, rst, in_valid && in_ready, ##1 q_valid, "accepted word missing from queue")
  // the back end never pops an empty queue
  `ASSERT_CLK(a_pop_nonempty, clk, rst, !q_pop || q_valid, "pop from empty queue")

endmodule
